// ===== design/asp_pkg.sv =====
// ----------------------------------------------------------------------------
// asp_pkg: shared types and constants for the auto-ranging point scaler
// Field widths, divider sizing, config register indexes, sequencer states.
// ----------------------------------------------------------------------------
package asp_pkg;

    localparam int COORD_BITS    = 12;
    localparam int OUT_BITS      = 12;
    localparam int DEN_BITS      = COORD_BITS + 1;
    localparam int PROD_BITS     = OUT_BITS + COORD_BITS;
    localparam int DIV_STEPS     = (PROD_BITS + 1) / 2;
    localparam int DIV_BITS      = 2 * DIV_STEPS;
    localparam int SIZE_STEPS    = (OUT_BITS + 1) / 2;
    localparam int SIZE_SHIFT    = DIV_BITS - 2 * SIZE_STEPS;
    localparam int CNT_BITS      = $clog2(DIV_STEPS + 1);
    localparam int CFG_DATA_BITS = OUT_BITS;

    localparam logic [OUT_BITS-1:0] OUT_SIZE_RESET = OUT_BITS'(256);

    localparam logic FUNC_MAP   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    typedef enum logic [1:0] {
        CFG_OUT_WIDTH  = 2'd0,
        CFG_OUT_HEIGHT = 2'd1,
        CFG_INVERT_X   = 2'd2,
        CFG_INVERT_Y   = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DIV_POS,
        ST_DIV_SIZE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic start;
        logic short_run;
    } div_ctl_t;

endpackage

// ===== design/asp_div.sv =====
// ----------------------------------------------------------------------------
// asp_div: shared restoring divider, two quotient bits per cycle
// Full run covers the product dividend; short run covers an output size
// placed in the top bits. done pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module asp_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  asp_pkg::div_ctl_t                ctl,
    input  logic [asp_pkg::DIV_BITS-1:0]     dividend,
    input  logic [asp_pkg::DEN_BITS-1:0]     divisor,
    output logic                             done,
    output logic [asp_pkg::OUT_BITS-1:0]     quotient
);
    import asp_pkg::*;

    logic [DIV_BITS-1:0] num_reg, num_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DEN_BITS:0]   step1, step2;

    function automatic logic [DEN_BITS:0] div_step(
        input logic [DEN_BITS-1:0] rem,
        input logic                bit_in,
        input logic [DEN_BITS-1:0] den
    );
        logic [DEN_BITS:0] t;
        logic [DEN_BITS:0] d;
        t = {rem, bit_in};
        d = {1'b0, den};
        if (t >= d)
        begin
            div_step = {1'b1, DEN_BITS'(t - d)};
        end
        else
        begin
            div_step = {1'b0, t[DEN_BITS-1:0]};
        end
    endfunction

    always_comb
    begin
        step1 = div_step(rem_reg, num_reg[DIV_BITS-1], den_reg);
        step2 = div_step(step1[DEN_BITS-1:0], num_reg[DIV_BITS-2], den_reg);

        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (ctl.start)
        begin
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = ctl.short_run ? CNT_BITS'(SIZE_STEPS) : CNT_BITS'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DIV_BITS-3:0], step1[DEN_BITS], step2[DEN_BITS]};
            rem_next = step2[DEN_BITS-1:0];
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg[OUT_BITS-1:0];

endmodule

// ===== design/auto_ranging_point_scaler.sv =====
// ----------------------------------------------------------------------------
// auto_ranging_point_scaler: running bounding box and cell mapping of points
// Tracks a box over incoming points and scales each point into an output cell.
// ----------------------------------------------------------------------------
// One item at a time. A mapped point passes, per axis, through a setup state,
// a multiply state, a full run of the shared two-bit-per-cycle divider for the
// corner and a short run for the cell size, then through a finish state that
// loads the output register once that register is free. A clear item or a
// point with a zero coordinate goes straight to the finish state. The result
// waits in an output register, so in_ready returns even while out_ready is
// low, as long as that register is free when the next result is done.
module auto_ranging_point_scaler
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  asp_pkg::cfg_index_t                 cfg_index,
    input  logic [asp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                func,
    input  logic [asp_pkg::COORD_BITS-1:0]      x_coord,
    input  logic [asp_pkg::COORD_BITS-1:0]      y_coord,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                valid_res,
    output logic [asp_pkg::OUT_BITS-1:0]        cell_x,
    output logic [asp_pkg::OUT_BITS-1:0]        cell_y,
    output logic [asp_pkg::OUT_BITS-1:0]        cell_width,
    output logic [asp_pkg::OUT_BITS-1:0]        cell_height
);
    import asp_pkg::*;

    state_t state_reg, state_next;

    // configuration
    logic [OUT_BITS-1:0]   out_width_reg, out_height_reg;
    logic                  invert_x_reg, invert_y_reg;

    // bounding box
    logic                  box_known_reg, box_known_next;
    logic [COORD_BITS-1:0] min_x_reg, min_x_next, max_x_reg, max_x_next;
    logic [COORD_BITS-1:0] min_y_reg, min_y_next, max_y_reg, max_y_next;

    // work registers
    logic [COORD_BITS-1:0] x_reg, x_next, y_reg, y_next;
    logic                  axis_reg, axis_next;
    logic [COORD_BITS-1:0] pos_reg, pos_next;
    logic [DEN_BITS-1:0]   den_reg, den_next;
    logic                  vres_reg, vres_next;
    logic [OUT_BITS-1:0]   cx_reg, cx_next, cy_reg, cy_next;
    logic [OUT_BITS-1:0]   cw_reg, cw_next, ch_reg, ch_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic                  valid_res_reg;
    logic [OUT_BITS-1:0]   cell_x_reg, cell_y_reg, cell_width_reg, cell_height_reg;

    // datapath
    logic                  accept;
    logic                  point_ok;
    logic                  out_free;
    logic [COORD_BITS-1:0] c_sel, lo_sel, hi_sel;
    logic [COORD_BITS-1:0] span, off;
    logic [OUT_BITS-1:0]   out_sel;
    logic                  inv_sel;
    logic [PROD_BITS-1:0]  product;
    div_ctl_t              div_ctl;
    logic [DIV_BITS-1:0]   div_dividend;
    logic                  div_done;
    logic [OUT_BITS-1:0]   div_quot;

    assign accept   = in_valid && in_ready;
    assign point_ok = (func == FUNC_MAP) && (x_coord != '0) && (y_coord != '0);
    assign out_free = !out_valid_reg || out_ready;

    assign c_sel   = (axis_reg == AXIS_Y) ? y_reg          : x_reg;
    assign lo_sel  = (axis_reg == AXIS_Y) ? min_y_reg      : min_x_reg;
    assign hi_sel  = (axis_reg == AXIS_Y) ? max_y_reg      : max_x_reg;
    assign out_sel = (axis_reg == AXIS_Y) ? out_height_reg : out_width_reg;
    assign inv_sel = (axis_reg == AXIS_Y) ? invert_y_reg   : invert_x_reg;
    assign span    = hi_sel - lo_sel;
    assign off     = c_sel - lo_sel;
    assign product = PROD_BITS'(out_sel) * PROD_BITS'(pos_reg);

    asp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = point_ok ? ST_SETUP : ST_FINISH;
                end
            end
            ST_SETUP:    state_next = ST_MUL;
            ST_MUL:      state_next = ST_DIV_POS;
            ST_DIV_POS:
            begin
                if (div_done)
                begin
                    state_next = ST_DIV_SIZE;
                end
            end
            ST_DIV_SIZE:
            begin
                if (div_done)
                begin
                    state_next = (axis_reg == AXIS_X) ? ST_SETUP : ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready          = 1'b0;
        div_ctl.start     = 1'b0;
        div_ctl.short_run = 1'b0;
        div_dividend      = DIV_BITS'(product);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_MUL:
            begin
                div_ctl.start = 1'b1;
            end
            ST_DIV_POS:
            begin
                div_ctl.start     = div_done;
                div_ctl.short_run = 1'b1;
                div_dividend      = DIV_BITS'(out_sel) << SIZE_SHIFT;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        box_known_next = box_known_reg;
        min_x_next     = min_x_reg;
        max_x_next     = max_x_reg;
        min_y_next     = min_y_reg;
        max_y_next     = max_y_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        axis_next      = axis_reg;
        pos_next       = pos_reg;
        den_next       = den_reg;
        vres_next      = vres_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cw_next        = cw_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (accept)
        begin
            x_next    = x_coord;
            y_next    = y_coord;
            axis_next = AXIS_X;
            vres_next = point_ok;
            cx_next   = '0;
            cy_next   = '0;
            cw_next   = '0;
            ch_next   = '0;
            if (func == FUNC_CLEAR)
            begin
                box_known_next = 1'b0;
                min_x_next     = '0;
                max_x_next     = '0;
                min_y_next     = '0;
                max_y_next     = '0;
            end
            else if (point_ok)
            begin
                box_known_next = 1'b1;
                if (!box_known_reg)
                begin
                    min_x_next = x_coord;
                    max_x_next = x_coord;
                    min_y_next = y_coord;
                    max_y_next = y_coord;
                end
                else
                begin
                    min_x_next = (x_coord < min_x_reg) ? x_coord : min_x_reg;
                    max_x_next = (x_coord > max_x_reg) ? x_coord : max_x_reg;
                    min_y_next = (y_coord < min_y_reg) ? y_coord : min_y_reg;
                    max_y_next = (y_coord > max_y_reg) ? y_coord : max_y_reg;
                end
            end
        end

        if (state_reg == ST_SETUP)
        begin
            pos_next = inv_sel ? (span - off) : off;
            den_next = DEN_BITS'(span) + DEN_BITS'(1);
        end

        if ((state_reg == ST_DIV_POS) && div_done)
        begin
            if (axis_reg == AXIS_Y)
            begin
                cy_next = div_quot;
            end
            else
            begin
                cx_next = div_quot;
            end
        end

        if ((state_reg == ST_DIV_SIZE) && div_done)
        begin
            if (axis_reg == AXIS_Y)
            begin
                ch_next = div_quot;
            end
            else
            begin
                cw_next   = div_quot;
                axis_next = AXIS_Y;
            end
        end

        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_width_reg  <= OUT_SIZE_RESET;
            out_height_reg <= OUT_SIZE_RESET;
            invert_x_reg   <= 1'b0;
            invert_y_reg   <= 1'b0;
            box_known_reg  <= 1'b0;
            min_x_reg      <= '0;
            max_x_reg      <= '0;
            min_y_reg      <= '0;
            max_y_reg      <= '0;
            axis_reg       <= AXIS_X;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            box_known_reg <= box_known_next;
            min_x_reg     <= min_x_next;
            max_x_reg     <= max_x_next;
            min_y_reg     <= min_y_next;
            max_y_reg     <= max_y_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_OUT_WIDTH:  out_width_reg  <= cfg_data[OUT_BITS-1:0];
                    CFG_OUT_HEIGHT: out_height_reg <= cfg_data[OUT_BITS-1:0];
                    CFG_INVERT_X:   invert_x_reg   <= cfg_data[0];
                    CFG_INVERT_Y:   invert_y_reg   <= cfg_data[0];
                    default:        invert_y_reg   <= invert_y_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        pos_reg  <= pos_next;
        den_reg  <= den_next;
        vres_reg <= vres_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cw_reg   <= cw_next;
        ch_reg   <= ch_next;
        if ((state_reg == ST_FINISH) && out_free)
        begin
            valid_res_reg   <= vres_reg;
            cell_x_reg      <= cx_reg;
            cell_y_reg      <= cy_reg;
            cell_width_reg  <= cw_reg;
            cell_height_reg <= ch_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign valid_res   = valid_res_reg;
    assign cell_x      = cell_x_reg;
    assign cell_y      = cell_y_reg;
    assign cell_width  = cell_width_reg;
    assign cell_height = cell_height_reg;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the auto-ranging point scaler
// Drives clear items, valid points and zero-coordinate points through the
// valid/ready input with random gaps and output stalls. A scoreboard tracks
// the bounding box and checks every result field by field, across a series of
// output size and inversion settings.
// ----------------------------------------------------------------------------
import asp_pkg::*;

typedef struct packed {
    logic                mapped;
    logic [OUT_BITS-1:0] cx;
    logic [OUT_BITS-1:0] cy;
    logic [OUT_BITS-1:0] cw;
    logic [OUT_BITS-1:0] ch;
} cell_result_t;

class scaler_scoreboard;
    logic [OUT_BITS-1:0]   out_w;
    logic [OUT_BITS-1:0]   out_h;
    logic                  inv_x;
    logic                  inv_y;
    logic                  box_valid;
    logic [COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y;
    cell_result_t          expected_cells[$];
    int unsigned           errors;

    function new();
        out_w     = OUT_SIZE_RESET;
        out_h     = OUT_SIZE_RESET;
        inv_x     = 1'b0;
        inv_y     = 1'b0;
        box_valid = 1'b0;
        lo_x      = '0;
        hi_x      = '0;
        lo_y      = '0;
        hi_y      = '0;
        errors    = 0;
    endfunction

    function void set_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] v);
        case (idx)
            CFG_OUT_WIDTH:  out_w = v;
            CFG_OUT_HEIGHT: out_h = v;
            CFG_INVERT_X:   inv_x = v[0];
            CFG_INVERT_Y:   inv_y = v[0];
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_cells.size();
    endfunction

    // widen one axis of the box, then scale the offset into the output
    function void scale_axis(input logic [COORD_BITS-1:0] c,
                             inout logic [COORD_BITS-1:0] lo,
                             inout logic [COORD_BITS-1:0] hi,
                             input logic inv, input logic [OUT_BITS-1:0] size,
                             output logic [OUT_BITS-1:0] corner,
                             output logic [OUT_BITS-1:0] cell_len);
        int unsigned span, pos, den;
        if (c < lo) lo = c;
        if (c > hi) hi = c;
        span = 32'(hi) - 32'(lo);
        pos  = 32'(c) - 32'(lo);
        if (inv) pos = span - pos;
        den      = span + 1;
        corner   = OUT_BITS'((32'(size) * pos) / den);
        cell_len = OUT_BITS'(32'(size) / den);
    endfunction

    function void note_item(input logic f, input logic [COORD_BITS-1:0] x,
                            input logic [COORD_BITS-1:0] y);
        cell_result_t        r;
        logic [OUT_BITS-1:0] cx, cy, cw, ch;
        r = '0;
        if (f == FUNC_CLEAR) begin
            box_valid = 1'b0;
            lo_x = '0;
            hi_x = '0;
            lo_y = '0;
            hi_y = '0;
        end
        else if (x != '0 && y != '0) begin
            if (!box_valid) begin
                box_valid = 1'b1;
                lo_x = x;
                hi_x = x;
                lo_y = y;
                hi_y = y;
            end
            scale_axis(x, lo_x, hi_x, inv_x, out_w, cx, cw);
            scale_axis(y, lo_y, hi_y, inv_y, out_h, cy, ch);
            r.mapped = 1'b1;
            r.cx = cx;
            r.cy = cy;
            r.cw = cw;
            r.ch = ch;
        end
        expected_cells.push_back(r);
    endfunction

    task report(input string what, input int unsigned got, input int unsigned want);
        $display("%0t MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    task check_result(input cell_result_t got);
        cell_result_t want;
        if (expected_cells.size() == 0) begin
            report("result with no item pending", 32'(got.mapped), 0);
            return;
        end
        want = expected_cells.pop_front();
        if (got.mapped !== want.mapped)
            report("valid_res", 32'(got.mapped), 32'(want.mapped));
        if (got.cx !== want.cx) report("cell_x", 32'(got.cx), 32'(want.cx));
        if (got.cy !== want.cy) report("cell_y", 32'(got.cy), 32'(want.cy));
        if (got.cw !== want.cw) report("cell_width", 32'(got.cw), 32'(want.cw));
        if (got.ch !== want.ch) report("cell_height", 32'(got.ch), 32'(want.ch));
    endtask
endclass

module tb_top;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    cfg_index_t               cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic                     func;
    logic [COORD_BITS-1:0]    x_coord;
    logic [COORD_BITS-1:0]    y_coord;
    logic                     out_valid;
    logic                     out_ready;
    logic                     valid_res;
    logic [OUT_BITS-1:0]      cell_x;
    logic [OUT_BITS-1:0]      cell_y;
    logic [OUT_BITS-1:0]      cell_width;
    logic [OUT_BITS-1:0]      cell_height;

    scaler_scoreboard sb = new();

    bit                    idle_on;
    bit                    stall_on;
    logic [COORD_BITS-1:0] base_x, base_y;
    int unsigned           rad_x, rad_y;

    auto_ranging_point_scaler dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .valid_res   (valid_res),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .cell_width  (cell_width),
        .cell_height (cell_height)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #5ms;
        $display("tb_top NOT OK");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({valid_res, cell_x, cell_y, cell_width, cell_height});
    end

    // output stalls
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic send_item(input logic f, input logic [COORD_BITS-1:0] x,
                             input logic [COORD_BITS-1:0] y);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        x_coord  <= x;
        y_coord  <= y;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_item(f, x, y);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        sb.set_reg(idx, v);
        @(negedge clk);
    endtask

    task automatic configure(input logic [OUT_BITS-1:0] w, input logic [OUT_BITS-1:0] h,
                             input logic ix, input logic iy);
        write_reg(CFG_OUT_WIDTH, w);
        write_reg(CFG_OUT_HEIGHT, h);
        write_reg(CFG_INVERT_X, {{(CFG_DATA_BITS-1){1'b0}}, ix});
        write_reg(CFG_INVERT_Y, {{(CFG_DATA_BITS-1){1'b0}}, iy});
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int unsigned pick_radius();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 1;
            2:       return 3;
            3:       return 15;
            4:       return 255;
            default: return 4094;
        endcase
    endfunction

    task automatic new_cluster();
        rad_x  = pick_radius();
        rad_y  = pick_radius();
        base_x = COORD_BITS'($urandom_range(1, 4095 - rad_x));
        base_y = COORD_BITS'($urandom_range(1, 4095 - rad_y));
    endtask

    task automatic run_points(input int n);
        int                    r;
        logic [COORD_BITS-1:0] x, y;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 7)
            begin
                send_item(FUNC_CLEAR, COORD_BITS'($urandom_range(0, 4095)),
                          COORD_BITS'($urandom_range(0, 4095)));
                new_cluster();
            end
            else if (r < 13)
            begin
                x = COORD_BITS'($urandom_range(0, 4095));
                y = COORD_BITS'($urandom_range(0, 4095));
                case ($urandom_range(0, 2))
                    0:       x = '0;
                    1:       y = '0;
                    default: begin x = '0; y = '0; end
                endcase
                send_item(FUNC_MAP, x, y);
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    x = COORD_BITS'($urandom_range(1, 4095));
                    y = COORD_BITS'($urandom_range(1, 4095));
                end
                else
                begin
                    x = COORD_BITS'(32'(base_x) + $urandom_range(0, rad_x));
                    y = COORD_BITS'(32'(base_y) + $urandom_range(0, rad_y));
                end
                send_item(FUNC_MAP, x, y);
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_OUT_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        func      = FUNC_MAP;
        x_coord   = '0;
        y_coord   = '0;
        idle_on   = 1'b1;
        stall_on  = 1'b1;
        new_cluster();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset settings, extremes, clears and ignored points
        send_item(FUNC_MAP, 12'd0, 12'd0);
        send_item(FUNC_MAP, 12'd1, 12'd1);
        send_item(FUNC_MAP, 12'd1, 12'd1);
        send_item(FUNC_MAP, 12'd4095, 12'd4095);
        send_item(FUNC_MAP, 12'd1, 12'd4095);
        send_item(FUNC_MAP, 12'd0, 12'd5);
        send_item(FUNC_MAP, 12'd5, 12'd0);
        send_item(FUNC_CLEAR, 12'd4095, 12'd4095);
        send_item(FUNC_MAP, 12'd2048, 12'd2048);
        send_item(FUNC_MAP, 12'd2048, 12'd2048);
        send_item(FUNC_MAP, 12'd2047, 12'd2049);
        send_item(FUNC_MAP, 12'd2730, 12'd1365);
        send_item(FUNC_CLEAR, 12'd0, 12'd0);
        send_item(FUNC_MAP, 12'd4095, 12'd1);
        send_item(FUNC_MAP, 12'd4094, 12'd2);
        send_item(FUNC_CLEAR, 12'd1, 12'd1);
        settle();

        configure(12'd1, 12'd1, 1'b0, 1'b0);
        run_points(55);
        settle();
        configure(12'd4095, 12'd4095, 1'b1, 1'b1);
        send_item(FUNC_CLEAR, 12'd0, 12'd0);
        send_item(FUNC_MAP, 12'd1, 12'd1);
        send_item(FUNC_MAP, 12'd4095, 12'd4095);
        send_item(FUNC_MAP, 12'd2000, 12'd3000);
        run_points(55);
        settle();
        configure(12'd4095, 12'd1, 1'b1, 1'b0);
        run_points(55);
        settle();
        configure(12'd0, 12'd4095, 1'b0, 1'b1);
        run_points(40);
        settle();
        configure(OUT_BITS'($urandom_range(1, 4095)), OUT_BITS'($urandom_range(1, 4095)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        run_points(60);
        settle();
        configure(12'd640, 12'd480, 1'b1, 1'b0);
        run_points(60);
        settle();
        configure(OUT_SIZE_RESET, OUT_SIZE_RESET, 1'b0, 1'b0);
        run_points(60);
        settle();
        configure(OUT_BITS'($urandom_range(1, 4095)), OUT_BITS'($urandom_range(1, 4095)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        idle_on  = 1'b0;
        stall_on = 1'b0;
        run_points(60);
        settle();

        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
design/asp_pkg.sv
design/asp_div.sv
design/auto_ranging_point_scaler.sv
bench/tb_top.sv
